>>> hdl/jsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

	localparam int PhaseW = 3;
	localparam logic [PhaseW-1:0] PH_PLAIN    = 3'd0;
	localparam logic [PhaseW-1:0] PH_ESC      = 3'd1;
	localparam logic [PhaseW-1:0] PH_HEX1     = 3'd2;
	localparam logic [PhaseW-1:0] PH_BSL      = 3'd3;
	localparam logic [PhaseW-1:0] PH_LETTER_U = 3'd4;
	localparam logic [PhaseW-1:0] PH_HEX2     = 3'd5;
	localparam logic [PhaseW-1:0] PH_SKIP     = 3'd6;

	localparam logic [2:0] ST_BYTE     = 3'd0;
	localparam logic [2:0] ST_DONE     = 3'd1;
	localparam logic [2:0] ST_CONTROL  = 3'd2;
	localparam logic [2:0] ST_BAD_ESC  = 3'd3;
	localparam logic [2:0] ST_BAD_HEX  = 3'd4;
	localparam logic [2:0] ST_BAD_SURR = 3'd5;
	localparam logic [2:0] ST_UNTERM   = 3'd6;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;

	localparam logic [15:0] SURR_HI_LO = 16'hD800;
	localparam logic [15:0] SURR_LO_LO = 16'hDC00;
	localparam logic [15:0] SURR_LO_HI = 16'hDFFF;
	localparam logic [10:0] PLANE1_HI  = 11'h040;

	localparam logic [7:0] UTF_CONT = 8'h80;
	localparam logic [7:0] UTF_LEAD2 = 8'hC0;
	localparam logic [7:0] UTF_LEAD3 = 8'hE0;
	localparam logic [7:0] UTF_LEAD4 = 8'hF0;

	typedef struct packed {
		logic [2:0]      nb;
		logic [3:0][7:0] bytes;
	} utf8_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hexd_t;

	function automatic hexd_t hex_digit(input logic [7:0] b);
		hexd_t r;
		r.ok  = 1'b1;
		r.val = 4'd0;
		if (b inside {[8'h30:8'h39]}) begin
			r.val = b[3:0];
		end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			r.val = b[3:0] + 4'd9;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

	function automatic utf8_t utf8_enc(input logic [20:0] cp);
		utf8_t r;
		r.bytes = '0;
		if (cp < 21'h80) begin
			r.nb       = 3'd1;
			r.bytes[0] = cp[7:0];
		end else if (cp < 21'h800) begin
			r.nb       = 3'd2;
			r.bytes[0] = UTF_LEAD2 | {3'b0, cp[10:6]};
			r.bytes[1] = UTF_CONT | {2'b0, cp[5:0]};
		end else if (cp < 21'h10000) begin
			r.nb       = 3'd3;
			r.bytes[0] = UTF_LEAD3 | {4'b0, cp[15:12]};
			r.bytes[1] = UTF_CONT | {2'b0, cp[11:6]};
			r.bytes[2] = UTF_CONT | {2'b0, cp[5:0]};
		end else begin
			r.nb       = 3'd4;
			r.bytes[0] = UTF_LEAD4 | {5'b0, cp[20:18]};
			r.bytes[1] = UTF_CONT | {2'b0, cp[17:12]};
			r.bytes[2] = UTF_CONT | {2'b0, cp[11:6]};
			r.bytes[3] = UTF_CONT | {2'b0, cp[5:0]};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hdl/json_string_unescaper_top.sv
`timescale 1ns / 1ps
`default_nettype none

// JSON string body unescaper. Feed the bytes after the opening quote on the s_ side,
// one byte a word, tlast marking the last byte of the text. Plain bytes pass through,
// simple escapes and \uXXXX (with surrogate pairs) come out as UTF-8 bytes, and a
// closing quote or an error ends the string with a status word on tuser (0 byte,
// 1 done, 2 control, 3 bad escape, 4 bad hex, 5 bad surrogate, 6 unterminated).
// An input word is decoded in the cycle it is accepted and its results (none to
// five) are held in one result stage that sends one word a cycle while m_tready is
// high; the next input word is taken in the same cycle the last result of the
// previous one leaves, or at once if the stage is empty, so the single output port
// sets the pace; prefix bytes and hex digits that end no code point give no results.

module json_string_unescaper_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,  // [7:0] data_byte
	input  wire logic       s_tlast,  // text_ends
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic      [7:0] m_tdata,  // [7:0] out_byte
	output logic      [2:0] m_tuser,  // [2:0] status
	output logic            m_tlast   // last result of the input word
);

	logic [jsu_pkg::PhaseW-1:0] phase_q, phase_d;
	logic [1:0]  hcnt_q, hcnt_d;
	logic [15:0] hval_q, hval_d;
	logic [9:0]  hhalf_q, hhalf_d;

	logic [2:0]      nres_s1, idx_s1, nb_s1;
	logic [3:0][7:0] bytes_s1;
	logic [2:0]      fin_s1;

	logic [2:0]      nb_d, fin_d, nres_d;
	logic [3:0][7:0] bytes_d;

	jsu_pkg::hexd_t  hd;
	jsu_pkg::utf8_t  enc;
	logic [15:0]     hnew;
	logic [20:0]     cp;
	logic            emit;
	logic            accept, pop, last_pop;

	assign hd   = jsu_pkg::hex_digit(s_tdata);
	assign hnew = {hval_q[11:0], hd.val};
	assign cp   = (phase_q == jsu_pkg::PH_HEX2)
		? {{1'b0, hhalf_q} + jsu_pkg::PLANE1_HI, hnew[9:0]} : {5'b0, hnew};
	assign enc  = jsu_pkg::utf8_enc(cp);

	always_comb begin
		phase_d = phase_q;
		hcnt_d  = hcnt_q;
		hval_d  = hval_q;
		hhalf_d = hhalf_q;
		nb_d    = 3'd0;
		bytes_d = '0;
		fin_d   = jsu_pkg::ST_BYTE;
		emit    = 1'b0;
		case (phase_q)
			jsu_pkg::PH_SKIP: begin
			end
			jsu_pkg::PH_ESC: begin
				phase_d = jsu_pkg::PH_PLAIN;
				nb_d    = 3'd1;
				case (s_tdata)
					jsu_pkg::CH_QUOTE: bytes_d[0] = jsu_pkg::CH_QUOTE;
					jsu_pkg::CH_BSL:   bytes_d[0] = jsu_pkg::CH_BSL;
					jsu_pkg::CH_SLASH: bytes_d[0] = jsu_pkg::CH_SLASH;
					jsu_pkg::CH_B:     bytes_d[0] = 8'h08;
					jsu_pkg::CH_F:     bytes_d[0] = 8'h0C;
					jsu_pkg::CH_N:     bytes_d[0] = 8'h0A;
					jsu_pkg::CH_R:     bytes_d[0] = 8'h0D;
					jsu_pkg::CH_T:     bytes_d[0] = 8'h09;
					jsu_pkg::CH_U: begin
						nb_d    = 3'd0;
						phase_d = jsu_pkg::PH_HEX1;
						hcnt_d  = 2'd0;
						hval_d  = 16'd0;
					end
					default: begin
						nb_d    = 3'd0;
						phase_d = phase_q;
						fin_d   = jsu_pkg::ST_BAD_ESC;
					end
				endcase
			end
			jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
				if (!hd.ok) begin
					fin_d = jsu_pkg::ST_BAD_HEX;
				end else begin
					hval_d = hnew;
					if (hcnt_q != 2'd3) begin
						hcnt_d = hcnt_q + 2'd1;
					end else begin
						hcnt_d = 2'd0;
						if (phase_q == jsu_pkg::PH_HEX1) begin
							if (hnew inside {[jsu_pkg::SURR_HI_LO:
									jsu_pkg::SURR_LO_LO - 16'd1]}) begin
								hhalf_d = hnew[9:0];
								phase_d = jsu_pkg::PH_BSL;
							end else if (hnew inside {[jsu_pkg::SURR_LO_LO:
									jsu_pkg::SURR_LO_HI]}) begin
								fin_d = jsu_pkg::ST_BAD_SURR;
							end else begin
								emit    = 1'b1;
								phase_d = jsu_pkg::PH_PLAIN;
							end
						end else begin
							if (hnew inside {[jsu_pkg::SURR_LO_LO:
									jsu_pkg::SURR_LO_HI]}) begin
								emit    = 1'b1;
								phase_d = jsu_pkg::PH_PLAIN;
							end else begin
								fin_d = jsu_pkg::ST_BAD_SURR;
							end
						end
					end
				end
			end
			jsu_pkg::PH_BSL: begin
				if (s_tdata == jsu_pkg::CH_BSL) begin
					phase_d = jsu_pkg::PH_LETTER_U;
				end else begin
					fin_d = jsu_pkg::ST_BAD_SURR;
				end
			end
			jsu_pkg::PH_LETTER_U: begin
				if (s_tdata == jsu_pkg::CH_U) begin
					phase_d = jsu_pkg::PH_HEX2;
					hcnt_d  = 2'd0;
					hval_d  = 16'd0;
				end else begin
					fin_d = jsu_pkg::ST_BAD_SURR;
				end
			end
			default: begin
				if (s_tdata < 8'h20) begin
					fin_d = jsu_pkg::ST_CONTROL;
				end else if (s_tdata == jsu_pkg::CH_QUOTE) begin
					fin_d = jsu_pkg::ST_DONE;
				end else if (s_tdata == jsu_pkg::CH_BSL) begin
					phase_d = jsu_pkg::PH_ESC;
				end else begin
					nb_d       = 3'd1;
					bytes_d[0] = s_tdata;
				end
			end
		endcase

		if (emit) begin
			nb_d    = enc.nb;
			bytes_d = enc.bytes;
		end

		// skip phase ignores end-of-text handling apart from leaving the skip
		if (phase_q == jsu_pkg::PH_SKIP) begin
			if (s_tlast) begin
				phase_d = jsu_pkg::PH_PLAIN;
			end
		end else if (fin_d != jsu_pkg::ST_BYTE || s_tlast) begin
			if (fin_d == jsu_pkg::ST_BYTE) begin
				fin_d = jsu_pkg::ST_UNTERM;
			end
			phase_d = s_tlast ? jsu_pkg::PH_PLAIN : jsu_pkg::PH_SKIP;
			hcnt_d  = 2'd0;
			hval_d  = 16'd0;
			hhalf_d = 10'd0;
		end
	end

	assign nres_d = nb_d + {2'b0, fin_d != jsu_pkg::ST_BYTE};

	assign m_tvalid = nres_s1 != 3'd0;
	assign pop      = m_tvalid && m_tready;
	assign last_pop = pop && (idx_s1 == nres_s1 - 3'd1);
	assign s_tready = !m_tvalid || last_pop;
	assign accept   = s_tvalid && s_tready;

	assign m_tdata = (idx_s1 < nb_s1) ? bytes_s1[idx_s1[1:0]] : 8'h00;
	assign m_tuser = (idx_s1 < nb_s1) ? jsu_pkg::ST_BYTE : fin_s1;
	assign m_tlast = idx_s1 == nres_s1 - 3'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= jsu_pkg::PH_PLAIN;
			hcnt_q  <= 2'd0;
			hval_q  <= 16'd0;
			hhalf_q <= 10'd0;
			nres_s1 <= 3'd0;
			idx_s1  <= 3'd0;
		end else begin
			if (accept) begin
				phase_q <= phase_d;
				hcnt_q  <= hcnt_d;
				hval_q  <= hval_d;
				hhalf_q <= hhalf_d;
				nres_s1 <= nres_d;
				idx_s1  <= 3'd0;
			end else if (last_pop) begin
				nres_s1 <= 3'd0;
				idx_s1  <= 3'd0;
			end else if (pop) begin
				idx_s1 <= idx_s1 + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			nb_s1    <= nb_d;
			bytes_s1 <= bytes_d;
			fin_s1   <= fin_d;
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> idx_s1 < nres_s1)
		else $error("result index beyond count");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != jsu_pkg::ST_BYTE) |-> (m_tlast && m_tdata == 8'h00))
		else $error("status word not last or carries data");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(idx_s1)))
		else $error("stalled result moved");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result stage");

endmodule

`default_nettype wire
